[rtl/core/tgbp_pkg.sv]
// Package: shared types and the grille cell-to-pass mapping for the block permuter.
package tgbp_pkg;

  localparam int BlockBits = 64;
  localparam int IdxBits   = 6;
  localparam int KeyBits   = 32;
  localparam int SubBits   = 3;
  localparam int SubCount  = 8;
  localparam int PassCount = 4;
  localparam int RankBits  = 4;

  typedef logic [IdxBits-1:0]                 idx_t;
  typedef logic [BlockBits-1:0][IdxBits-1:0]  table_t;
  typedef logic [BlockBits-1:0][SubCount-1:0] cand_t;
  typedef logic [KeyBits-1:0]                 key_t;
  typedef logic [1:0]                         pass_t;

  localparam logic [1:0] QuadUL = 2'b00;
  localparam logic [1:0] QuadUR = 2'b01;
  localparam logic [1:0] QuadLR = 2'b11;
  localparam logic [1:0] QuadLL = 2'b10;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  // Pass in which grid cell g gets marked: undo the quarter turn to find the
  // quadrant cell, then p = (t - q) mod 4.
  function automatic pass_t cell_pass(input key_t key, input idx_t g);
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] r;
    logic [1:0] c;
    logic [1:0] t;
    logic [1:0] q;
    row = g[5:3];
    col = g[2:0];
    case ({row[2], col[2]})
      QuadUL: begin
        t = 2'd0; r = row[1:0];  c = col[1:0];
      end
      QuadUR: begin
        t = 2'd1; r = ~col[1:0]; c = row[1:0];
      end
      QuadLR: begin
        t = 2'd2; r = ~row[1:0]; c = ~col[1:0];
      end
      default: begin
        t = 2'd3; r = col[1:0];  c = ~row[1:0];
      end
    endcase
    q = key[{r, c, 1'b0} +: 2];
    return pass_t'(t - q);
  endfunction

endpackage

[rtl/core/turning_grille_block_permuter.sv]
// Top level of the turning-grille 64-bit block permuter.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid/cfg_ready    cipher_key[31:0]
//   in       in         in_valid/in_ready      command, data_block[63:0]
//   out      out        out_valid/out_ready    result_block[63:0]
//
// One transaction per cycle while the table is built and the output is not stalled; each input
// transaction is registered in the input, low-bit select and output registers in turn.
// After reset and after every key write the table sweep runs over all 64 grid cells, one grid
// cell per cycle, with in_ready low; cfg is always ready.
// A stalled output backs up through the three stages; nothing is dropped or repeated.
module turning_grille_block_permuter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  tgbp_pkg::key_t                   cipher_key,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [tgbp_pkg::BlockBits-1:0]   data_block,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tgbp_pkg::BlockBits-1:0]   result_block
);

  logic             built;
  tgbp_pkg::table_t fwd_tbl;
  tgbp_pkg::table_t inv_tbl;

  assign cfg_ready = 1'b1;

  tgbp_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_key   (cipher_key),
    .built     (built),
    .fwd_tbl   (fwd_tbl),
    .inv_tbl   (inv_tbl)
  );

  tgbp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .enable       (built),
    .fwd_tbl      (fwd_tbl),
    .inv_tbl      (inv_tbl),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_block   (data_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block)
  );

endmodule

[rtl/core/tgbp_table.sv]
// Key register and sweep that builds the forward and inverse position tables.
module tgbp_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  tgbp_pkg::key_t    cfg_key,
  output logic              built,
  output tgbp_pkg::table_t  fwd_tbl,
  output tgbp_pkg::table_t  inv_tbl
);

  typedef enum logic {ST_BUILD, ST_RUN} state_t;

  state_t                                  state;
  tgbp_pkg::key_t                          key;
  tgbp_pkg::idx_t                          cell_cnt;
  logic [tgbp_pkg::PassCount-1:0][tgbp_pkg::RankBits-1:0] pass_cnt;

  tgbp_pkg::pass_t cur_pass;
  tgbp_pkg::idx_t  cur_idx;

  assign cur_pass = tgbp_pkg::cell_pass(key, cell_cnt);
  assign cur_idx  = {cur_pass, pass_cnt[cur_pass]};
  assign built    = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_BUILD;
      key      <= '0;
      cell_cnt <= '0;
      pass_cnt <= '0;
    end else if (cfg_write) begin
      state    <= ST_BUILD;
      key      <= cfg_key;
      cell_cnt <= '0;
      pass_cnt <= '0;
    end else begin
      case (state)
        ST_BUILD: begin
          pass_cnt[cur_pass] <= pass_cnt[cur_pass] + 1'b1;
          cell_cnt           <= cell_cnt + 1'b1;
          if (cell_cnt == tgbp_pkg::idx_t'(tgbp_pkg::BlockBits - 1)) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  // fwd: grid cell -> source bit for encrypt; inv: table slot -> grid cell
  always_ff @(posedge clk) begin
    if (state == ST_BUILD && !cfg_write) begin
      fwd_tbl[cell_cnt] <= cur_idx;
      inv_tbl[cur_idx]  <= cell_cnt;
    end
  end

endmodule

[rtl/core/tgbp_datapath.sv]
// Three-stage bit-select pipeline: input register, low-bit select, high-bit select.
module tgbp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                enable,
  input  tgbp_pkg::table_t                    fwd_tbl,
  input  tgbp_pkg::table_t                    inv_tbl,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [tgbp_pkg::BlockBits-1:0]      data_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tgbp_pkg::BlockBits-1:0]      result_block
);

  logic                               v1, v2, v3;
  logic                               rdy1, rdy2, rdy3;
  logic                               cmd1, cmd2;
  logic [tgbp_pkg::BlockBits-1:0]     data1;
  tgbp_pkg::cand_t                    cand2;
  tgbp_pkg::cand_t                    cand_next;
  logic [tgbp_pkg::BlockBits-1:0]     result_next;
  tgbp_pkg::idx_t                     sel1 [tgbp_pkg::BlockBits];
  tgbp_pkg::idx_t                     sel2 [tgbp_pkg::BlockBits];

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = enable && rdy1;

  always_comb begin
    for (int g = 0; g < tgbp_pkg::BlockBits; g++) begin
      sel1[g] = (cmd1 == tgbp_pkg::CmdDecrypt) ? inv_tbl[g] : fwd_tbl[g];
      sel2[g] = (cmd2 == tgbp_pkg::CmdDecrypt) ? inv_tbl[g] : fwd_tbl[g];
      for (int h = 0; h < tgbp_pkg::SubCount; h++) begin
        cand_next[g][h] = data1[{h[tgbp_pkg::SubBits-1:0],
                                 sel1[g][tgbp_pkg::SubBits-1:0]}];
      end
      result_next[g] = cand2[g][sel2[g][tgbp_pkg::IdxBits-1:tgbp_pkg::SubBits]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid && in_ready;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid && in_ready) begin
      cmd1  <= command;
      data1 <= data_block;
    end
    if (rdy2 && v1) begin
      cmd2  <= cmd1;
      cand2 <= cand_next;
    end
    if (rdy3 && v2) begin
      result_block <= result_next;
    end
  end

  assign out_valid = v3;

endmodule

[rtl/core/tgbp_checker.sv]
// Port-level checks for the block permuter, bound to the top level.
module tgbp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tgbp_pkg::BlockBits-1:0] result_block
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_block))
    else $error("output transaction changed while stalled");

  a_reset_build: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready && !out_valid)
    else $error("input open or output valid right after reset");

  a_key_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input open during table rebuild");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("transaction not delivered after three cycles");

endmodule

bind turning_grille_block_permuter tgbp_checker u_tgbp_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_block (result_block)
);

[bench/tb_turning_grille_block_permuter.sv]
// Testbench: compares each permuted block from the turning-grille permuter with a grille predictor.
module tb_turning_grille_block_permuter;

  localparam int StuckLimit = 4000;
  localparam int HoldOffCycles = 200;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  tgbp_pkg::key_t cipher_key;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [tgbp_pkg::BlockBits-1:0] data_block;
  logic out_valid;
  logic out_ready;
  logic [tgbp_pkg::BlockBits-1:0] result_block;

  turning_grille_block_permuter uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cipher_key   (cipher_key),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .data_block   (data_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block)
  );

  tgbp_pkg::table_t grille_tbl;
  logic [tgbp_pkg::BlockBits-1:0] pending_blocks[$];
  logic [tgbp_pkg::BlockBits-1:0] exp_block;
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_hold_cycles;
  int blocks_sent;
  int blocks_checked;
  int keys_loaded;
  int error_count;
  int report_count;
  int stuck_cycles;

  // Grille table: four passes, each marking the turned quadrant cells, read row-major.
  function automatic tgbp_pkg::table_t build_grille(input tgbp_pkg::key_t key);
    tgbp_pkg::table_t tbl;
    logic [tgbp_pkg::BlockBits-1:0] marks;
    logic [1:0] turn;
    int n;
    tbl = '0;
    n = 0;
    for (int p = 0; p < tgbp_pkg::PassCount; p++) begin
      marks = '0;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          turn = p[1:0] + key[(4*r + c)*2 +: 2];
          case (turn)
            2'd0: marks[8*r + c] = 1'b1;
            2'd1: marks[8*c + 7 - r] = 1'b1;
            2'd2: marks[8*(7 - r) + 7 - c] = 1'b1;
            default: marks[8*(7 - c) + r] = 1'b1;
          endcase
        end
      end
      for (int g = 0; g < tgbp_pkg::BlockBits; g++) begin
        if (marks[g] && n < tgbp_pkg::BlockBits) begin
          tbl[n] = tgbp_pkg::idx_t'(g);
          n++;
        end
      end
    end
    return tbl;
  endfunction

  function automatic logic [tgbp_pkg::BlockBits-1:0] permute_block(
      input tgbp_pkg::table_t tbl, input logic cmd,
      input logic [tgbp_pkg::BlockBits-1:0] src);
    logic [tgbp_pkg::BlockBits-1:0] dst;
    dst = '0;
    for (int n = 0; n < tgbp_pkg::BlockBits; n++) begin
      if (cmd == tgbp_pkg::CmdEncrypt) begin
        dst[tbl[n]] = dst[tbl[n]] | src[n];
      end else begin
        dst[n] = src[tbl[n]];
      end
    end
    return dst;
  endfunction

  function automatic logic [tgbp_pkg::BlockBits-1:0] rand_block();
    logic [tgbp_pkg::BlockBits-1:0] blk;
    case ($urandom_range(0, 7))
      0: blk = 64'd1 << $urandom_range(0, 63);
      1: blk = ~(64'd1 << $urandom_range(0, 63));
      default: blk = {$urandom, $urandom};
    endcase
    return blk;
  endfunction

  function automatic logic rand_command();
    return ($urandom_range(0, 1) != 0) ? tgbp_pkg::CmdDecrypt : tgbp_pkg::CmdEncrypt;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic wait_drained();
    while (pending_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic send_block(input logic cmd, input logic [tgbp_pkg::BlockBits-1:0] blk);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    data_block = blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    pending_blocks.push_back(permute_block(grille_tbl, cmd, blk));
    blocks_sent++;
  endtask

  task automatic write_key(input tgbp_pkg::key_t k);
    wait_drained();
    cfg_valid = 1'b1;
    cipher_key = k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    grille_tbl = build_grille(k);
    keys_loaded++;
  endtask

  // Extreme blocks under the reset key, then all-ones and uniform-rotation keys.
  task automatic test_directed();
    logic [tgbp_pkg::BlockBits-1:0] blocks[6];
    blocks[0] = 64'h0;
    blocks[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    blocks[2] = 64'h1;
    blocks[3] = 64'h8000_0000_0000_0000;
    blocks[4] = 64'h5555_5555_5555_5555;
    blocks[5] = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 0; i < 6; i++) begin
      send_block(tgbp_pkg::CmdEncrypt, blocks[i]);
      send_block(tgbp_pkg::CmdDecrypt, blocks[i]);
    end
    write_key(32'hFFFF_FFFF);
    send_block(tgbp_pkg::CmdEncrypt, 64'h0123_4567_89AB_CDEF);
    send_block(tgbp_pkg::CmdDecrypt, 64'h0123_4567_89AB_CDEF);
    send_block(tgbp_pkg::CmdEncrypt, 64'h0000_0000_0000_0080);
    send_block(tgbp_pkg::CmdDecrypt, 64'h0100_0000_0000_0000);
    write_key(32'h5555_5555);
    send_block(tgbp_pkg::CmdEncrypt, 64'hFEDC_BA98_7654_3210);
    send_block(tgbp_pkg::CmdDecrypt, 64'hFEDC_BA98_7654_3210);
    write_key(32'hAAAA_AAAA);
    send_block(tgbp_pkg::CmdEncrypt, 64'h00FF_00FF_0F0F_3333);
    send_block(tgbp_pkg::CmdDecrypt, 64'h00FF_00FF_0F0F_3333);
  endtask

  task automatic test_random_keys();
    tgbp_pkg::key_t keys[5];
    keys[0] = $urandom;
    keys[1] = 32'h0;
    keys[2] = $urandom;
    keys[3] = 32'hFFFF_FFFF;
    keys[4] = $urandom;
    for (int k = 0; k < 5; k++) begin
      write_key(keys[k]);
      repeat (200) send_block(rand_command(), rand_block());
    end
  endtask

  task automatic test_back_to_back();
    write_key($urandom);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    repeat (100) send_block(rand_command(), rand_block());
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Receiver stops for a long stretch while the sender keeps offering blocks.
  task automatic test_output_hold_off();
    tx_no_idle = 1'b1;
    rx_hold_cycles = HoldOffCycles;
    repeat (40) send_block(rand_command(), rand_block());
    tx_no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    repeat (30) send_block(rand_command(), rand_block());
    wait_drained();
    repeat (30) send_block(rand_command(), rand_block());
  endtask

  // Output side: random stall per transaction, plus an occasional long hold-off.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int stall;
      if (rx_hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_blocks.size() == 0) begin
          error_count++;
          if (report_count < 10) begin
            $display("ERROR: result %h with no block outstanding", result_block);
          end
          report_count++;
        end else begin
          exp_block = pending_blocks.pop_front();
          blocks_checked++;
          if (result_block !== exp_block) begin
            error_count++;
            if (report_count < 10) begin
              $display("ERROR: result_block expected %h actual %h", exp_block, result_block);
            end
            report_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("Timeout: no transaction for %0d cycles", StuckLimit);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cipher_key = '0;
    in_valid = 1'b0;
    command = tgbp_pkg::CmdEncrypt;
    data_block = '0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    rx_hold_cycles = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    keys_loaded = 0;
    error_count = 0;
    report_count = 0;
    stuck_cycles = 0;
    grille_tbl = build_grille('0);
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_keys();
    test_back_to_back();
    test_output_hold_off();
    test_sender_pause();

    wait_drained();
    repeat (8) @(negedge clk);
    error_count += pending_blocks.size();

    $display("Checked %0d of %0d blocks, encrypt and decrypt, across %0d key loads.",
             blocks_checked, blocks_sent, keys_loaded);
    $display("Traffic included back-to-back streams, a long output hold-off and a drain pause.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[turning_grille_block_permuter.f]
rtl/core/tgbp_pkg.sv
rtl/core/tgbp_table.sv
rtl/core/tgbp_datapath.sv
rtl/core/turning_grille_block_permuter.sv
rtl/core/tgbp_checker.sv
bench/tb_turning_grille_block_permuter.sv
